@@ rtl/rttl_pkg.sv @@
`default_nettype none
package rttl_pkg;

    localparam int MAX_CHANNELS   = 16;
    localparam int MAX_NAME_CHARS = 32;
    localparam int MAX_INT_DIGITS = 31;

    localparam int DUR_W     = 29;
    localparam int DEN_W     = 38;
    localparam int DIV_STEPS = DUR_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [DUR_W-1:0] CAP_US   = 29'd360000000;
    localparam logic [DUR_W-1:0] PLAIN_US = 29'd240000000;

    typedef enum logic [4:0] {
        PH_LEAD, PH_NAME, PH_KEY, PH_EQ, PH_SETNUM, PH_SETSEP, PH_GAP, PH_DUR,
        PH_NAMECH, PH_DOT1, PH_OCT, PH_DOT2, PH_VIB, PH_VFREQ0, PH_VFREQ,
        PH_VVAR, PH_SEP, PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_FEED, S_DIV, S_FINISH, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        EV_NOTE  = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2
    } t_event;

    localparam logic [3:0] E_NONE    = 4'd0;
    localparam logic [3:0] E_EOF     = 4'd1;
    localparam logic [3:0] E_NAMELEN = 4'd2;
    localparam logic [3:0] E_NOEQ    = 4'd3;
    localparam logic [3:0] E_KEY     = 4'd4;
    localparam logic [3:0] E_NOINT   = 4'd5;
    localparam logic [3:0] E_INTLONG = 4'd6;
    localparam logic [3:0] E_DUR     = 4'd7;
    localparam logic [3:0] E_OCT     = 4'd8;
    localparam logic [3:0] E_SETSEP  = 4'd9;
    localparam logic [3:0] E_NONAME  = 4'd10;
    localparam logic [3:0] E_NOTE    = 4'd11;
    localparam logic [3:0] E_CHAN    = 4'd12;
    localparam logic [3:0] E_BLOCK   = 4'd13;
    localparam logic [3:0] E_SEP     = 4'd14;

    localparam logic [2:0] KEY_NONE = 3'd0;
    localparam logic [2:0] KEY_BPM  = 3'd1;
    localparam logic [2:0] KEY_DIV  = 3'd2;
    localparam logic [2:0] KEY_OCT  = 3'd3;
    localparam logic [2:0] KEY_VF   = 3'd4;
    localparam logic [2:0] KEY_VV   = 3'd5;

    localparam logic [4:0] NOTE_REST = 5'd18;
    localparam logic [4:0] NOTE_HASH = 5'd26;
    localparam logic [4:0] NOTE_BAD  = 5'd31;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LF_   = 8'h66;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    localparam logic [4:0] N_A = 5'd0;
    localparam logic [4:0] N_B = 5'd1;
    localparam logic [4:0] N_C = 5'd2;
    localparam logic [4:0] N_D = 5'd3;
    localparam logic [4:0] N_E = 5'd4;
    localparam logic [4:0] N_F = 5'd5;
    localparam logic [4:0] N_G = 5'd6;
    localparam logic [4:0] N_P = 5'd15;

    typedef struct packed {
        t_event      ev;
        logic [3:0]  err;
        logic [4:0]  chan;
        logic [4:0]  pcode;
        logic [3:0]  oct;
        logic [5:0]  div;
        logic        dot;
        logic [22:0] pitch;
        logic [15:0] vf;
        logic [15:0] vv;
    } t_res;

    typedef struct packed {
        logic load;
        logic feed;
        logic finish;
        logic div_run;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic       again;
        logic       note;
        logic       eot;
        logic       div_done;
        logic [1:0] cnt;
        logic       out_last;
    } t_sts;

    typedef struct packed {
        logic        fail;
        logic [31:0] num;
        logic [4:0]  dig;
    } t_digit;

    // Octave 4 pitch times 16000, truncated.
    function automatic logic [22:0] pitch_base(input logic [4:0] pc);
        logic [22:0] t;
        case (pc)
            5'd0:    t = 23'd4186009;
            5'd1:    t = 23'd4434922;
            5'd2:    t = 23'd4434922;
            5'd3:    t = 23'd4698636;
            5'd4:    t = 23'd4978031;
            5'd5:    t = 23'd4978031;
            5'd6:    t = 23'd5274040;
            5'd7:    t = 23'd5587651;
            5'd8:    t = 23'd5587651;
            5'd9:    t = 23'd5919910;
            5'd10:   t = 23'd5919910;
            5'd11:   t = 23'd6271926;
            5'd12:   t = 23'd6644875;
            5'd13:   t = 23'd6644875;
            5'd14:   t = 23'd7040000;
            5'd15:   t = 23'd7458620;
            5'd16:   t = 23'd7458620;
            5'd17:   t = 23'd7902132;
            default: t = 23'd0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] resolve1(input logic [4:0] f);
        logic [4:0] r;
        case (f)
            N_P:     r = NOTE_REST;
            N_C:     r = 5'd0;
            N_D:     r = 5'd3;
            N_E:     r = 5'd6;
            N_F:     r = 5'd8;
            N_G:     r = 5'd11;
            N_A:     r = 5'd14;
            N_B:     r = 5'd17;
            default: r = NOTE_BAD;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] resolve2(input logic [4:0] f, input logic [7:0] s);
        logic [4:0] r;
        r = NOTE_BAD;
        if (s == CH_HASH) begin
            case (f)
                N_C:     r = 5'd1;
                N_D:     r = 5'd4;
                N_E:     r = 5'd7;
                N_F:     r = 5'd9;
                N_G:     r = 5'd12;
                N_A:     r = 5'd15;
                default: r = NOTE_BAD;
            endcase
        end else if (s == CH_LB) begin
            case (f)
                N_D:     r = 5'd2;
                N_E:     r = 5'd5;
                N_G:     r = 5'd10;
                N_A:     r = 5'd13;
                N_B:     r = 5'd16;
                default: r = NOTE_BAD;
            endcase
        end
        return r;
    endfunction

    function automatic logic valid_div(input logic [31:0] d);
        return d == 32'd1 || d == 32'd2 || d == 32'd4 || d == 32'd8 ||
               d == 32'd16 || d == 32'd32;
    endfunction

    function automatic logic [2:0] div_shift(input logic [5:0] d);
        logic [2:0] s;
        case (d)
            6'd2:    s = 3'd1;
            6'd4:    s = 3'd2;
            6'd8:    s = 3'd3;
            6'd16:   s = 3'd4;
            6'd32:   s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic t_digit take_digit(input logic [31:0] num, input logic [4:0] dig,
                                          input logic [7:0] c);
        t_digit     r;
        logic [35:0] v;
        v = ({4'd0, num} << 3) + ({4'd0, num} << 1) + {28'd0, c - CH_0};
        r.fail = dig >= 5'(MAX_INT_DIGITS);
        r.num  = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
        r.dig  = dig + 5'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/rttl_ctrl.sv @@
`default_nettype none
module rttl_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    input  rttl_pkg::t_sts    i_sts,
    output rttl_pkg::t_cmd    o_cmd
);
    import rttl_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_state after_feed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign after_feed = i_sts.eot ? S_FINISH : S_OUT;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_FEED;
            end
            S_FEED: begin
                if (i_sts.note) begin
                    n_state = S_DIV;
                    n_ret   = i_sts.again ? S_FEED : after_feed;
                end else if (!i_sts.again) begin
                    n_state = after_feed;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = r_ret;
            end
            S_FINISH: begin
                if (i_sts.note) begin
                    n_state = S_DIV;
                    n_ret   = S_OUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.cnt == 2'd0) n_state = S_IDLE;
                else if (i_m_tready && i_sts.out_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        o_m_tvalid     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_FEED:   o_cmd.feed    = 1'b1;
            S_DIV:    o_cmd.div_run = 1'b1;
            S_FINISH: o_cmd.finish  = 1'b1;
            S_OUT: begin
                o_m_tvalid     = i_sts.cnt != 2'd0;
                o_cmd.out_next = i_m_tready && (i_sts.cnt != 2'd0) && !i_sts.out_last;
            end
            default: o_cmd = '0;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input and output handshakes open together");
    a_accept_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_state == S_FEED)
        else $error("accepted byte not parsed");
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && i_sts.out_last) |=> r_state == S_IDLE)
        else $error("no return to idle after last result");
    a_div_from_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == S_DIV)) |-> $past(i_sts.note))
        else $error("divider entered without a note");

endmodule
`default_nettype wire

@@ rtl/rttl_dp.sv @@
`default_nettype none
module rttl_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  rttl_pkg::t_cmd    i_cmd,
    input  wire [7:0]         i_char,
    input  wire               i_eot,
    input  wire               i_vib_en,
    output rttl_pkg::t_sts    o_sts,
    output rttl_pkg::t_res    o_res,
    output logic [28:0]       o_dur
);
    import rttl_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_ic, n_ic;
    logic [5:0]  r_name_len, n_name_len;
    logic [31:0] r_num, n_num;
    logic [4:0]  r_dig, n_dig;
    logic [2:0]  r_key, n_key;
    logic [31:0] r_bpm, n_bpm;
    logic [5:0]  r_ddiv, n_ddiv;
    logic [3:0]  r_doct, n_doct;
    logic [15:0] r_dvf, n_dvf;
    logic [15:0] r_dvv, n_dvv;
    logic [4:0]  r_ncode, n_ncode;
    logic [5:0]  r_ndiv, n_ndiv;
    logic [3:0]  r_noct, n_noct;
    logic        r_ndot, n_ndot;
    logic [15:0] r_nvf, n_nvf;
    logic [15:0] r_nvv, n_nvv;
    logic [4:0]  r_chan, n_chan;
    logic [4:0]  r_bcc, n_bcc;
    logic        r_any, n_any;

    logic [7:0]  r_char;
    logic        r_eot;
    t_res        r_slot0, r_slot1;
    logic [1:0]  r_cnt;
    logic        r_oidx;

    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [DUR_W-1:0]  r_dvd;
    logic [DUR_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_dcnt;

    logic        fail, emit_n, emit_d, again;
    logic [3:0]  fcode;
    logic        blank, sk, sk_ic, dig_c;
    logic [7:0]  lc;
    logic [4:0]  code;
    logic [4:0]  chan_inc;
    logic [4:0]  bcc_sel;
    t_digit      td;
    t_res        rec_note, rec_done, rec_err, rec_a;
    logic        rec_a_v, rec_b_v, push;
    logic [30:0] pitch_sh;
    logic [DEN_W-1:0] den_new;
    logic [DEN_W:0]   rem_sh;
    logic             rem_ge;

    assign blank  = (r_char == CH_TAB) || (r_char == CH_SP) || (r_char == CH_VT) ||
                    (r_char == CH_LF);
    assign sk     = r_ic || blank || (r_char == CH_HASH);
    assign sk_ic  = r_ic ? (r_char != CH_LF) : (r_char == CH_HASH);
    assign dig_c  = is_digit(r_char);
    assign td     = take_digit(r_num, r_dig, r_char);
    assign lc     = (r_char >= CH_UA && r_char <= CH_UZ) ? r_char + 8'd32 : r_char;
    assign chan_inc = r_chan + 5'd1;

    always_comb begin
        n_phase = r_phase;  n_ic = r_ic;  n_name_len = r_name_len;
        n_num = r_num;  n_dig = r_dig;  n_key = r_key;  n_bpm = r_bpm;
        n_ddiv = r_ddiv;  n_doct = r_doct;  n_dvf = r_dvf;  n_dvv = r_dvv;
        n_ncode = r_ncode;  n_ndiv = r_ndiv;  n_noct = r_noct;  n_ndot = r_ndot;
        n_nvf = r_nvf;  n_nvv = r_nvv;  n_chan = r_chan;  n_bcc = r_bcc;  n_any = r_any;
        fail = 1'b0;  fcode = E_NONE;  emit_n = 1'b0;  emit_d = 1'b0;  again = 1'b0;
        code = NOTE_BAD;

        if (i_cmd.finish) begin
            case (r_phase)
                PH_GAP: begin
                    if (r_any) emit_d = 1'b1;
                    else begin fail = 1'b1; fcode = E_EOF; end
                end
                PH_NAMECH: begin
                    code = (r_dig != 5'd0) ? resolve1(r_ncode) : NOTE_BAD;
                    if (code == NOTE_BAD) begin
                        fail  = 1'b1;
                        fcode = (r_dig != 5'd0) ? E_NOTE : E_NONAME;
                    end else begin
                        n_ncode = code;  emit_n = 1'b1;  emit_d = 1'b1;
                    end
                end
                PH_VFREQ: begin
                    n_nvf = r_num[15:0];  emit_n = 1'b1;  emit_d = 1'b1;
                end
                PH_VVAR: begin
                    if (r_dig == 5'd0) begin fail = 1'b1; fcode = E_NOINT; end
                    else begin n_nvv = r_num[15:0]; emit_n = 1'b1; emit_d = 1'b1; end
                end
                PH_DOT1, PH_OCT, PH_DOT2, PH_VIB, PH_VFREQ0: begin
                    emit_n = 1'b1;  emit_d = 1'b1;
                end
                PH_SEP:  emit_d = 1'b1;
                PH_HALT: emit_d = 1'b0;
                default: begin fail = 1'b1; fcode = E_EOF; end
            endcase
        end else begin
            case (r_phase)
                PH_LEAD: begin
                    if (sk) n_ic = sk_ic;
                    else begin n_name_len = 6'd1; n_phase = PH_NAME; end
                end
                PH_NAME: begin
                    if (r_char == CH_COLON) n_phase = PH_KEY;
                    else if (r_name_len >= 6'(MAX_NAME_CHARS - 1)) begin
                        fail = 1'b1;  fcode = E_NAMELEN;
                    end else n_name_len = r_name_len + 6'd1;
                end
                PH_KEY: begin
                    if (sk) n_ic = sk_ic;
                    else if (r_char == CH_COLON) n_phase = PH_GAP;
                    else begin
                        case (r_char)
                            CH_LB:   n_key = KEY_BPM;
                            CH_LD:   n_key = KEY_DIV;
                            CH_LO:   n_key = KEY_OCT;
                            CH_LF_:  n_key = KEY_VF;
                            CH_LV:   n_key = KEY_VV;
                            default: n_key = KEY_NONE;
                        endcase
                        n_phase = PH_EQ;
                    end
                end
                PH_EQ: begin
                    if (sk) n_ic = sk_ic;
                    else if (r_char != CH_EQ) begin fail = 1'b1; fcode = E_NOEQ; end
                    else if (r_key == KEY_NONE) begin fail = 1'b1; fcode = E_KEY; end
                    else begin n_num = '0; n_dig = '0; n_phase = PH_SETNUM; end
                end
                PH_SETNUM: begin
                    if (dig_c) begin
                        if (td.fail) begin fail = 1'b1; fcode = E_INTLONG; end
                        else begin n_num = td.num; n_dig = td.dig; end
                    end else if (r_dig == 5'd0) begin
                        fail = 1'b1;  fcode = E_NOINT;
                    end else begin
                        case (r_key)
                            KEY_BPM: n_bpm = r_num;
                            KEY_DIV: begin
                                if (!valid_div(r_num)) begin fail = 1'b1; fcode = E_DUR; end
                                else n_ddiv = r_num[5:0];
                            end
                            KEY_OCT: begin
                                if (r_num > 32'd8) begin fail = 1'b1; fcode = E_OCT; end
                                else n_doct = r_num[3:0];
                            end
                            KEY_VF:  n_dvf = r_num[15:0];
                            default: n_dvv = r_num[15:0];
                        endcase
                        n_phase = PH_SETSEP;
                        again   = 1'b1;
                    end
                end
                PH_SETSEP: begin
                    if (sk) n_ic = sk_ic;
                    else if (r_char == CH_COMMA) n_phase = PH_KEY;
                    else if (r_char == CH_COLON) n_phase = PH_GAP;
                    else begin fail = 1'b1; fcode = E_SETSEP; end
                end
                PH_GAP: begin
                    if (sk) n_ic = sk_ic;
                    else begin
                        n_ndiv = r_ddiv;  n_noct = r_doct;  n_ndot = 1'b0;
                        n_nvf = '0;  n_nvv = '0;  n_num = '0;  n_dig = '0;
                        n_phase = dig_c ? PH_DUR : PH_NAMECH;
                        again = 1'b1;
                    end
                end
                PH_DUR: begin
                    if (dig_c) begin
                        if (td.fail) begin fail = 1'b1; fcode = E_INTLONG; end
                        else begin n_num = td.num; n_dig = td.dig; end
                    end else if (!valid_div(r_num)) begin
                        fail = 1'b1;  fcode = E_DUR;
                    end else begin
                        n_ndiv = r_num[5:0];  n_dig = '0;  n_phase = PH_NAMECH;
                        again = 1'b1;
                    end
                end
                PH_NAMECH: begin
                    if ((lc >= CH_LA && lc <= CH_LZ) || lc == CH_HASH) begin
                        if (r_dig == 5'd0) begin
                            n_ncode = (lc == CH_HASH) ? NOTE_HASH : 5'(lc - CH_LA);
                            n_dig   = 5'd1;
                        end else begin
                            code = resolve2(r_ncode, lc);
                            if (code == NOTE_BAD) begin fail = 1'b1; fcode = E_NOTE; end
                            else begin n_ncode = code; n_phase = PH_DOT1; end
                        end
                    end else if (r_dig == 5'd0) begin
                        fail = 1'b1;  fcode = E_NONAME;
                    end else begin
                        code = resolve1(r_ncode);
                        if (code == NOTE_BAD) begin fail = 1'b1; fcode = E_NOTE; end
                        else begin n_ncode = code; n_phase = PH_DOT1; again = 1'b1; end
                    end
                end
                PH_DOT1: begin
                    n_phase = PH_OCT;
                    if (r_char == CH_DOT) n_ndot = 1'b1;
                    else again = 1'b1;
                end
                PH_OCT: begin
                    if (dig_c) begin
                        if (r_char > CH_8) begin fail = 1'b1; fcode = E_OCT; end
                        else begin n_noct = r_char[3:0]; n_phase = PH_DOT2; end
                    end else begin
                        n_phase = PH_DOT2;  again = 1'b1;
                    end
                end
                PH_DOT2: begin
                    n_phase = PH_VIB;
                    if (r_char == CH_DOT) n_ndot = 1'b1;
                    else again = 1'b1;
                end
                PH_VIB: begin
                    if (r_char == CH_LV) begin
                        n_nvf = r_dvf;  n_nvv = r_dvv;  n_phase = PH_VFREQ0;
                    end else begin
                        emit_n = 1'b1;  n_phase = PH_SEP;  again = 1'b1;
                    end
                end
                PH_VFREQ0: begin
                    if (dig_c) begin n_num = '0; n_dig = '0; n_phase = PH_VFREQ; end
                    else begin emit_n = 1'b1; n_phase = PH_SEP; end
                    again = 1'b1;
                end
                PH_VFREQ: begin
                    if (dig_c) begin
                        if (td.fail) begin fail = 1'b1; fcode = E_INTLONG; end
                        else begin n_num = td.num; n_dig = td.dig; end
                    end else begin
                        n_nvf = r_num[15:0];
                        if (r_char == CH_MINUS) begin
                            n_num = '0;  n_dig = '0;  n_phase = PH_VVAR;
                        end else begin
                            emit_n = 1'b1;  n_phase = PH_SEP;  again = 1'b1;
                        end
                    end
                end
                PH_VVAR: begin
                    if (dig_c) begin
                        if (td.fail) begin fail = 1'b1; fcode = E_INTLONG; end
                        else begin n_num = td.num; n_dig = td.dig; end
                    end else if (r_dig == 5'd0) begin
                        fail = 1'b1;  fcode = E_NOINT;
                    end else begin
                        n_nvv = r_num[15:0];  emit_n = 1'b1;  n_phase = PH_SEP;
                        again = 1'b1;
                    end
                end
                PH_SEP: begin
                    if (sk) n_ic = sk_ic;
                    else if (r_char == CH_BAR) begin
                        if ({1'b0, r_chan} + 6'd1 >= 6'(MAX_CHANNELS)) begin
                            fail = 1'b1;  fcode = E_CHAN;
                        end else begin
                            n_chan = chan_inc;  n_phase = PH_GAP;
                        end
                    end else if (r_char == CH_SEMI) begin
                        n_bcc = (r_bcc == 5'd0) ? chan_inc : r_bcc;
                        if (n_bcc != chan_inc) begin fail = 1'b1; fcode = E_BLOCK; end
                        else begin n_chan = '0; n_phase = PH_GAP; end
                    end else if (r_char == CH_COMMA) begin
                        n_phase = PH_GAP;
                    end else begin
                        fail = 1'b1;  fcode = E_SEP;
                    end
                end
                default: again = 1'b0;
            endcase
        end

        if (fail) begin
            n_phase = PH_HALT;
            n_ic    = 1'b0;
            again   = 1'b0;
        end
        if (emit_n) n_any = 1'b1;
    end

    // Result records built from the updated note fields.
    assign pitch_sh = {8'd0, pitch_base(n_ncode)} << n_noct;
    assign bcc_sel  = (r_bcc != 5'd0) ? r_bcc : ((r_any || emit_n) ? 5'd1 : 5'd0);

    always_comb begin
        rec_note       = '0;
        rec_note.ev    = EV_NOTE;
        rec_note.chan  = n_chan;
        rec_note.pcode = n_ncode;
        rec_note.oct   = n_noct;
        rec_note.div   = n_ndiv;
        rec_note.dot   = n_ndot;
        rec_note.pitch = (n_ncode < NOTE_REST && n_noct <= 4'd8) ? pitch_sh[30:8] : 23'd0;
        rec_note.vf    = i_vib_en ? n_nvf : 16'd0;
        rec_note.vv    = i_vib_en ? n_nvv : 16'd0;
        rec_done       = '0;
        rec_done.ev    = EV_DONE;
        rec_done.chan  = bcc_sel;
        rec_err        = '0;
        rec_err.ev     = EV_ERROR;
        rec_err.err    = fcode;
        rec_a          = emit_n ? rec_note : (fail ? rec_err : rec_done);
    end

    assign rec_a_v = emit_n || fail || emit_d;
    assign rec_b_v = emit_n && emit_d;
    assign push    = i_cmd.feed || i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.finish)) begin
            r_phase <= PH_LEAD;  r_ic <= 1'b0;  r_name_len <= '0;  r_num <= '0;
            r_dig <= '0;  r_key <= KEY_NONE;  r_bpm <= '0;  r_ddiv <= 6'd8;
            r_doct <= 4'd4;  r_dvf <= '0;  r_dvv <= '0;  r_ncode <= '0;
            r_ndiv <= 6'd8;  r_noct <= 4'd4;  r_ndot <= 1'b0;  r_nvf <= '0;
            r_nvv <= '0;  r_chan <= '0;  r_bcc <= '0;  r_any <= 1'b0;
        end else if (i_cmd.feed) begin
            r_phase <= n_phase;  r_ic <= n_ic;  r_name_len <= n_name_len;
            r_num <= n_num;  r_dig <= n_dig;  r_key <= n_key;  r_bpm <= n_bpm;
            r_ddiv <= n_ddiv;  r_doct <= n_doct;  r_dvf <= n_dvf;  r_dvv <= n_dvv;
            r_ncode <= n_ncode;  r_ndiv <= n_ndiv;  r_noct <= n_noct;
            r_ndot <= n_ndot;  r_nvf <= n_nvf;  r_nvv <= n_nvv;  r_chan <= n_chan;
            r_bcc <= n_bcc;  r_any <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char;
            r_eot  <= i_eot;
        end
    end

    // Up to two results per byte; anything past the second is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_oidx <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt  <= '0;
            r_oidx <= 1'b0;
        end else if (i_cmd.out_next) begin
            r_oidx <= 1'b1;
        end else if (push && rec_a_v) begin
            if (r_cnt == 2'd0) r_cnt <= rec_b_v ? 2'd2 : 2'd1;
            else if (r_cnt == 2'd1) r_cnt <= 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && rec_a_v) begin
            if (r_cnt == 2'd0) begin
                r_slot0 <= rec_a;
                if (rec_b_v) r_slot1 <= rec_done;
            end else if (r_cnt == 2'd1) begin
                r_slot1 <= rec_a;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign den_new = {6'd0, n_bpm} << div_shift(n_ndiv);
    assign rem_sh  = {r_rem, r_dvd[DUR_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (push && emit_n) begin
            r_dcnt <= (den_new == '0) ? '0 : DCNT_W'(DIV_STEPS);
        end else if (i_cmd.div_run && r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && emit_n) begin
            r_den <= den_new;
            r_rem <= '0;
            r_dvd <= n_ndot ? CAP_US : PLAIN_US;
            r_quo <= (den_new == '0) ? CAP_US : '0;
        end else if (i_cmd.div_run && r_dcnt != '0) begin
            r_rem <= rem_ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_dvd <= {r_dvd[DUR_W-2:0], 1'b0};
            r_quo <= {r_quo[DUR_W-2:0], rem_ge};
        end
    end

    assign o_res = r_oidx ? r_slot1 : r_slot0;
    assign o_dur = r_quo;

    always_comb begin
        o_sts          = '0;
        o_sts.again    = again;
        o_sts.note     = emit_n;
        o_sts.eot      = r_eot;
        o_sts.div_done = r_dcnt == '0;
        o_sts.cnt      = r_cnt;
        o_sts.out_last = r_oidx || (r_cnt == 2'd1);
    end

    a_one_note: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.feed && emit_n) |-> !fail)
        else $error("note and error from one parse pass");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count overflow");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_next) |-> r_dcnt == '0)
        else $error("result sent while divider busy");

endmodule
`default_nettype wire

@@ rtl/ringtone_text_note_parser.sv @@
`default_nettype none
// Ringtone text parser. Text bytes enter on the slave stream, one byte per
// transaction, with tlast marking the final byte of a text. Results leave
// on the master stream: tuser carries the event kind, tlast flags the last
// result caused by one input byte, tdata carries the note fields.
// Each byte is accepted, then parsed in one or more passes, then its
// results (up to two) are sent while the receiver is ready. A note also
// runs the duration division, which iterates one quotient bit per cycle.
// The parser handles one byte at a time, so the slave side is not ready
// while results are pending; a stalled receiver simply holds the block in
// its output phase with tdata steady.
// Reset returns the parser to the start of a text and sets the vibrato
// enable register (APB address 0, bit 0) to one. After the final byte of a
// text the parser returns to its reset state, except for that register.
module ringtone_text_note_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // [7:0] char_code
    input  wire         i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [3:0] error_code, [8:4] channel, [13:9] pitch_code, [17:14] octave,
    // [23:18] duration_divisor, [24] dotted, [47:25] pitch_mhz,
    // [76:48] duration_us, [92:77] vibrato_freq, [108:93] vibrato_var
    output logic [111:0] o_m_tdata,
    output logic [1:0]  o_m_tuser,   // [1:0] event_res
    output logic        o_m_tlast,   // run_last
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire [2:0]   i_paddr,
    input  wire [31:0]  i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import rttl_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    t_res        res;
    logic [28:0] dur;
    logic        r_vib_en;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vib_en <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && !i_paddr[2]) begin
            r_vib_en <= i_pwdata[0];
        end
    end

    assign o_prdata = {31'd0, r_vib_en && !i_paddr[2]};

    rttl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rttl_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_char   (i_s_tdata),
        .i_eot    (i_s_tlast),
        .i_vib_en (r_vib_en),
        .o_sts    (sts),
        .o_res    (res),
        .o_dur    (dur)
    );

    assign o_m_tuser = res.ev;
    assign o_m_tlast = sts.out_last;
    assign o_m_tdata = {3'd0, res.vv, res.vf, (res.ev == EV_NOTE) ? dur : 29'd0,
                        res.pitch, res.dot, res.div, res.oct, res.pcode, res.chan,
                        res.err};

endmodule
`default_nettype wire

@@ sim/ringtone_text_note_parser_test.sv @@
`timescale 1ns / 1ps
module ringtone_text_note_parser_test;
    import rttl_pkg::*;

    localparam logic [2:0] VIB_EN_ADDR = 3'd0;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [1:0]  ev;
        logic [3:0]  err;
        logic [4:0]  chan;
        logic [4:0]  pcode;
        logic [3:0]  oct;
        logic [5:0]  dv;
        logic        dot;
        logic [22:0] pitch;
        logic [28:0] us;
        logic [15:0] vf;
        logic [15:0] vv;
        logic        last;
    } note_res_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    ringtone_text_note_parser i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // Parser mirror state.
    logic        vib_en;
    t_phase      ph;
    logic        cmt;
    int unsigned nlen, numv, ndig, key, bpm, ddiv, doct, dvf, dvv;
    int unsigned ncode, ndiv, noct, ndot, nvf, nvv, chan, blk_cnt, seen;

    note_res_t   step_out[$];
    note_res_t   expected_q[$];
    logic [7:0]  text_q[$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit div_ok(int unsigned d);
        return d == 1 || d == 2 || d == 4 || d == 8 || d == 16 || d == 32;
    endfunction

    function automatic int unsigned single_name(int unsigned f);
        case (f)
            15: return NOTE_REST;
            2: return 0;
            3: return 3;
            4: return 6;
            5: return 8;
            6: return 11;
            0: return 14;
            1: return 17;
            default: return NOTE_BAD;
        endcase
    endfunction

    function automatic int unsigned pair_name(int unsigned f, logic [7:0] s);
        if (s == "#") begin
            case (f)
                2: return 1;
                3: return 4;
                4: return 7;
                5: return 9;
                6: return 12;
                0: return 15;
                default: return NOTE_BAD;
            endcase
        end else if (s == "b") begin
            case (f)
                3: return 2;
                4: return 5;
                6: return 10;
                0: return 13;
                1: return 16;
                default: return NOTE_BAD;
            endcase
        end
        return NOTE_BAD;
    endfunction

    function automatic longint unsigned base_tone(int unsigned pc);
        case (pc)
            0: return 4186009;
            1, 2: return 4434922;
            3: return 4698636;
            4, 5: return 4978031;
            6: return 5274040;
            7, 8: return 5587651;
            9, 10: return 5919910;
            11: return 6271926;
            12, 13: return 6644875;
            14: return 7040000;
            15, 16: return 7458620;
            default: return 7902132;
        endcase
    endfunction

    function automatic note_res_t blank_res();
        note_res_t r;
        r = '{default: 0};
        return r;
    endfunction

    task automatic add_res(note_res_t r);
        if (step_out.size() < 2) step_out.push_back(r);
    endtask

    task automatic parse_error(logic [3:0] code);
        note_res_t r;
        r = blank_res();
        r.ev = EV_ERROR;
        r.err = code;
        add_res(r);
        ph = PH_HALT;
        cmt = 1'b0;
    endtask

    task automatic text_done();
        note_res_t r;
        r = blank_res();
        r.ev = EV_DONE;
        r.chan = blk_cnt != 0 ? blk_cnt : (seen != 0 ? 1 : 0);
        add_res(r);
    endtask

    task automatic note_out();
        note_res_t r;
        longint unsigned den, us;
        r = blank_res();
        r.ev = EV_NOTE;
        r.chan = chan;
        r.pcode = ncode;
        r.oct = noct;
        r.dv = ndiv;
        r.dot = ndot;
        if (ncode < 18 && noct <= 8) r.pitch = (base_tone(ncode) << noct) >> 8;
        den = longint'(bpm) * longint'(ndiv & 63);
        if (den == 0) us = 360000000;
        else us = (ndot ? 64'd360000000 : 64'd240000000) / den;
        r.us = us > 360000000 ? 360000000 : us;
        if (vib_en) begin
            r.vf = nvf;
            r.vv = nvv;
        end
        add_res(r);
        seen = 1;
    endtask

    function automatic bit blank_skip(logic [7:0] c);
        if (cmt) begin
            if (c == "\n") cmt = 1'b0;
            return 1;
        end
        if (c == "\t" || c == " " || c == 8'h0B || c == "\n") return 1;
        if (c == "#") begin
            cmt = 1'b1;
            return 1;
        end
        return 0;
    endfunction

    task automatic push_digit(logic [7:0] c);
        longint unsigned v;
        if (ndig >= MAX_INT_DIGITS) begin
            parse_error(E_INTLONG);
            return;
        end
        v = longint'(numv) * 10 + (c - "0");
        numv = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v;
        ndig++;
    endtask

    task automatic store_setting();
        case (key)
            KEY_BPM: bpm = numv;
            KEY_DIV: begin
                if (!div_ok(numv)) begin
                    parse_error(E_DUR);
                    return;
                end
                ddiv = numv;
            end
            KEY_OCT: begin
                if (numv > 8) begin
                    parse_error(E_OCT);
                    return;
                end
                doct = numv;
            end
            KEY_VF: dvf = numv & 16'hFFFF;
            default: dvv = numv & 16'hFFFF;
        endcase
        ph = PH_SETSEP;
    endtask

    task automatic parser_clear();
        ph = PH_LEAD;
        cmt = 0; nlen = 0; numv = 0; ndig = 0; key = KEY_NONE; bpm = 0;
        ddiv = 8; doct = 4; dvf = 0; dvv = 0;
        ncode = 0; ndiv = 8; noct = 4; ndot = 0; nvf = 0; nvv = 0;
        chan = 0; blk_cnt = 0; seen = 0;
    endtask

    task automatic parse_byte(logic [7:0] c);
        bit again;
        logic [7:0] lc;
        int unsigned code;
        again = 1;
        while (again) begin
            again = 0;
            case (ph)
                PH_LEAD: if (!blank_skip(c)) begin
                    nlen = 1;
                    ph = PH_NAME;
                end
                PH_NAME: begin
                    if (c == ":") ph = PH_KEY;
                    else if (nlen >= MAX_NAME_CHARS - 1) parse_error(E_NAMELEN);
                    else nlen++;
                end
                PH_KEY: if (!blank_skip(c)) begin
                    if (c == ":") ph = PH_GAP;
                    else begin
                        key = c == "b" ? KEY_BPM : c == "d" ? KEY_DIV : c == "o" ? KEY_OCT :
                              c == "f" ? KEY_VF : c == "v" ? KEY_VV : KEY_NONE;
                        ph = PH_EQ;
                    end
                end
                PH_EQ: if (!blank_skip(c)) begin
                    if (c != "=") parse_error(E_NOEQ);
                    else if (key == KEY_NONE) parse_error(E_KEY);
                    else begin
                        numv = 0;
                        ndig = 0;
                        ph = PH_SETNUM;
                    end
                end
                PH_SETNUM: begin
                    if (is_num(c)) push_digit(c);
                    else if (ndig == 0) parse_error(E_NOINT);
                    else begin
                        store_setting();
                        again = ph == PH_SETSEP;
                    end
                end
                PH_SETSEP: if (!blank_skip(c)) begin
                    if (c == ",") ph = PH_KEY;
                    else if (c == ":") ph = PH_GAP;
                    else parse_error(E_SETSEP);
                end
                PH_GAP: if (!blank_skip(c)) begin
                    ndiv = ddiv; noct = doct; ndot = 0; nvf = 0; nvv = 0;
                    numv = 0; ndig = 0;
                    ph = is_num(c) ? PH_DUR : PH_NAMECH;
                    again = 1;
                end
                PH_DUR: begin
                    if (is_num(c)) push_digit(c);
                    else if (!div_ok(numv)) parse_error(E_DUR);
                    else begin
                        ndiv = numv;
                        ndig = 0;
                        ph = PH_NAMECH;
                        again = 1;
                    end
                end
                PH_NAMECH: begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                    if ((lc >= "a" && lc <= "z") || lc == "#") begin
                        if (ndig == 0) begin
                            ncode = lc == "#" ? NOTE_HASH : lc - "a";
                            ndig = 1;
                        end else begin
                            code = pair_name(ncode, lc);
                            if (code == NOTE_BAD) parse_error(E_NOTE);
                            else begin
                                ncode = code;
                                ph = PH_DOT1;
                            end
                        end
                    end else if (ndig == 0) begin
                        parse_error(E_NONAME);
                    end else begin
                        code = single_name(ncode);
                        if (code == NOTE_BAD) parse_error(E_NOTE);
                        else begin
                            ncode = code;
                            ph = PH_DOT1;
                            again = 1;
                        end
                    end
                end
                PH_DOT1: begin
                    ph = PH_OCT;
                    if (c == ".") ndot = 1; else again = 1;
                end
                PH_OCT: begin
                    if (is_num(c)) begin
                        if (c > "8") parse_error(E_OCT);
                        else begin
                            noct = c - "0";
                            ph = PH_DOT2;
                        end
                    end else begin
                        ph = PH_DOT2;
                        again = 1;
                    end
                end
                PH_DOT2: begin
                    ph = PH_VIB;
                    if (c == ".") ndot = 1; else again = 1;
                end
                PH_VIB: begin
                    if (c == "v") begin
                        nvf = dvf;
                        nvv = dvv;
                        ph = PH_VFREQ0;
                    end else begin
                        note_out();
                        ph = PH_SEP;
                        again = 1;
                    end
                end
                PH_VFREQ0: begin
                    if (is_num(c)) begin
                        numv = 0;
                        ndig = 0;
                        ph = PH_VFREQ;
                    end else begin
                        note_out();
                        ph = PH_SEP;
                    end
                    again = 1;
                end
                PH_VFREQ: if (is_num(c)) push_digit(c);
                else begin
                    nvf = numv & 16'hFFFF;
                    if (c == "-") begin
                        numv = 0;
                        ndig = 0;
                        ph = PH_VVAR;
                    end else begin
                        note_out();
                        ph = PH_SEP;
                        again = 1;
                    end
                end
                PH_VVAR: if (is_num(c)) push_digit(c);
                else if (ndig == 0) parse_error(E_NOINT);
                else begin
                    nvv = numv & 16'hFFFF;
                    note_out();
                    ph = PH_SEP;
                    again = 1;
                end
                PH_SEP: if (!blank_skip(c)) begin
                    if (c == "|") begin
                        if (chan + 1 >= MAX_CHANNELS) parse_error(E_CHAN);
                        else begin
                            chan++;
                            ph = PH_GAP;
                        end
                    end else if (c == ";") begin
                        if (blk_cnt == 0) blk_cnt = chan + 1;
                        if (blk_cnt != chan + 1) parse_error(E_BLOCK);
                        else begin
                            chan = 0;
                            ph = PH_GAP;
                        end
                    end else if (c == ",") ph = PH_GAP;
                    else parse_error(E_SEP);
                end
                default: ;
            endcase
        end
    endtask

    task automatic parse_end();
        int unsigned code;
        case (ph)
            PH_GAP: if (seen != 0) text_done(); else parse_error(E_EOF);
            PH_NAMECH: begin
                code = ndig != 0 ? single_name(ncode) : NOTE_BAD;
                if (code == NOTE_BAD) parse_error(ndig != 0 ? E_NOTE : E_NONAME);
                else begin
                    ncode = code;
                    note_out();
                    text_done();
                end
            end
            PH_VFREQ: begin
                nvf = numv & 16'hFFFF;
                note_out();
                text_done();
            end
            PH_VVAR: if (ndig == 0) parse_error(E_NOINT);
            else begin
                nvv = numv & 16'hFFFF;
                note_out();
                text_done();
            end
            PH_DOT1, PH_OCT, PH_DOT2, PH_VIB, PH_VFREQ0: begin
                note_out();
                text_done();
            end
            PH_SEP: text_done();
            PH_HALT: ;
            default: parse_error(E_EOF);
        endcase
    endtask

    task automatic predict_byte(logic [7:0] c, logic eot);
        step_out.delete();
        parse_byte(c);
        if (eot) begin
            parse_end();
            parser_clear();
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[k]) expected_q.push_back(step_out[k]);
    endtask

    // Drives one byte; the valid stays high into the next byte when no gap follows.
    task automatic send_byte(logic [7:0] c, logic eot);
        int g;
        g = quiet ? 0 : gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eot;
        do @(posedge i_clk); while (!s_tready);
        predict_byte(c, eot);
        bytes_sent++;
    endtask

    task automatic add_str(string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic play_text();
        for (int k = 0; k < text_q.size(); k++) send_byte(text_q[k], k == text_q.size() - 1);
        text_q.delete();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic play(string s);
        add_str(s);
        play_text();
    endtask

    task automatic wait_idle();
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vib_enable(logic v);
        wait_idle();
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= VIB_EN_ADDR;
        pwdata <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        vib_en = v;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        note_res_t e, a;
        if (i_rst_n && m_tvalid && m_tready) begin
            a.ev = m_tuser;
            a.err = m_tdata[3:0];
            a.chan = m_tdata[8:4];
            a.pcode = m_tdata[13:9];
            a.oct = m_tdata[17:14];
            a.dv = m_tdata[23:18];
            a.dot = m_tdata[24];
            a.pitch = m_tdata[47:25];
            a.us = m_tdata[76:48];
            a.vf = m_tdata[92:77];
            a.vv = m_tdata[108:93];
            a.last = m_tlast;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", a);
            end else begin
                e = expected_q.pop_front();
                if (a !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch:\n  expected %p\n  actual   %p", e, a);
                end
            end
        end
    end

    // Receiver stalls.
    always @(negedge i_clk) begin
        int g;
        if (!i_rst_n || quiet) m_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            g = gap_len();
            stall_left <= g > 0 ? g - 1 : 0;
            m_tready <= g == 0;
        end
    end

    function automatic string num_str(int unsigned n);
        return $sformatf("%0d", n);
    endfunction

    function automatic string random_note();
        string names[19] = '{"c", "c#", "db", "d", "d#", "eb", "e", "e#", "f", "f#",
                             "gb", "g", "g#", "ab", "a", "a#", "bb", "b", "p"};
        int unsigned divs[6] = '{1, 2, 4, 8, 16, 32};
        string s, n;
        s = "";
        if ($urandom_range(0, 2) == 0) s = num_str(divs[$urandom_range(0, 5)]);
        else if ($urandom_range(0, 40) == 0) s = num_str($urandom_range(0, 64));
        n = names[$urandom_range(0, 18)];
        if ($urandom_range(0, 3) == 0) n = n.toupper();
        s = {s, n};
        if ($urandom_range(0, 4) == 0) s = {s, "."};
        if ($urandom_range(0, 1) == 0) s = {s, num_str($urandom_range(0, 8))};
        if ($urandom_range(0, 4) == 0) s = {s, "."};
        case ($urandom_range(0, 5))
            0: s = {s, "v"};
            1: s = {s, "v", num_str($urandom_range(0, 70000))};
            2: s = {s, "v", num_str($urandom_range(0, 300)), "-", num_str($urandom)};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string random_blank();
        case ($urandom_range(0, 7))
            0: return " ";
            1: return "\n\t";
            2: return "# note\n";
            3: return {" ", 8'h0B};
            default: return "";
        endcase
    endfunction

    task automatic build_song();
        int nch, nblk, nnotes;
        string s;
        s = random_blank();
        for (int k = $urandom_range(1, 8); k > 0; k--) s = {s, 8'($urandom_range(33, 126))};
        s = {s.substr(0, s.len() - 1), ":"};
        if (s[0] == ":") s = {"n", s};
        if ($urandom_range(0, 3) != 0) s = {s, "b=", num_str($urandom_range(0, 400))};
        else s = {s, "b=", num_str($urandom)};
        if ($urandom_range(0, 1)) s = {s, ",", random_blank(), "d=",
                                       num_str(1 << $urandom_range(0, 5))};
        if ($urandom_range(0, 1)) s = {s, ", o=", num_str($urandom_range(0, 8))};
        if ($urandom_range(0, 1)) s = {s, ",f=", num_str($urandom_range(0, 70000))};
        if ($urandom_range(0, 1)) s = {s, ",v=", num_str($urandom_range(0, 70000))};
        s = {s, random_blank(), ":", random_blank()};
        nch = $urandom_range(0, 9) == 0 ? 16 : $urandom_range(1, 3);
        nblk = $urandom_range(1, 2);
        for (int b = 0; b < nblk; b++) begin
            for (int ch = 0; ch < nch; ch++) begin
                nnotes = $urandom_range(1, 3);
                for (int k = 0; k < nnotes; k++) begin
                    s = {s, random_note()};
                    if (k < nnotes - 1) s = {s, ",", random_blank()};
                end
                if (ch < nch - 1) s = {s, random_blank(), "|", random_blank()};
            end
            if (b < nblk - 1 || $urandom_range(0, 1)) s = {s, ";", random_blank()};
        end
        add_str(s);
        // Occasional corruption of one byte.
        if ($urandom_range(0, 7) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = $urandom_range(0, 255);
    endtask

    task automatic test_basic_notes();
        play("x:b=0:c");
        play("tune:d=32,o=8,b=999999:32B#.8.,p,1a0;");
        play("#hi\n\t n:b=120:2C.,Eb8.,G#|4f0;");
    endtask

    task automatic test_vibrato();
        play("v:f=7,v=65539:g5v12-65539,a5v,b");
        write_vib_enable(1'b0);
        play("v:f=300,v=20:a4v400-5,c");
        write_vib_enable(1'b1);
    endtask

    task automatic test_errors();
        string s;
        play("n");
        s = "";
        for (int k = 0; k < MAX_NAME_CHARS; k++) s = {s, "a"};
        play({s, ":"});
        play("n:b5");
        play("n:z=");
        play("n:b=:");
        s = "n:b=";
        for (int k = 0; k <= MAX_INT_DIGITS; k++) s = {s, "9"};
        play(s);
        play("n:d=3,");
        play("n:o=9,");
        play("n:b=9x");
        play("n::.");
        play("n::cb");
        s = "n::";
        for (int k = 0; k < MAX_CHANNELS; k++) s = {s, "c|"};
        play(s);
        play("n::c|c;c;");
        play("n::c x");
        play("n::c,");
        play("n::c9");
        play("n:b=1:2v3-;");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        add_str(":b=4294967299:");
        play_text();
    endtask

    task automatic test_random_songs();
        while (bytes_sent < 400 + 600) begin
            if ($urandom_range(0, 4) == 0) write_vib_enable($urandom_range(0, 1));
            quiet = $urandom_range(0, 5) == 0;
            if ($urandom_range(0, 5) == 0) begin
                for (int k = $urandom_range(1, 10); k > 0; k--)
                    text_q.push_back($urandom_range(0, 255));
            end else build_song();
            play_text();
        end
        quiet = 1'b0;
    endtask

    initial begin
        parser_clear();
        vib_en = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_notes();
        test_vibrato();
        test_errors();
        write_vib_enable(1'b1);
        test_random_songs();
        write_vib_enable(1'b0);
        play("e:b=60:c,p");
        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rttl_pkg.sv
rtl/rttl_ctrl.sv
rtl/rttl_dp.sv
rtl/ringtone_text_note_parser.sv
sim/ringtone_text_note_parser_test.sv
